[src/msort_pkg.sv]
// ----------------------------------------------------------------------------
// msort_pkg: shared types and constants for the merge sorter
// Item format between the intake side and the sort core, plus queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package msort_pkg;

  // Width of the value fields on the ports
  localparam int VALUE_W = 32;

  // Intake queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // One classified item as it travels through the intake queue
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;  // already reduced to the element width
    logic                      last;   // closes the set, starts the sort
    logic                      drop;   // store was full when it arrived
  } qentry_t;

endpackage

`default_nettype wire

[src/merge_sorter.sv]
// ----------------------------------------------------------------------------
// merge_sorter: streaming merge sort of a set of signed values
// Loads a set of values, sorts it by bottom-up merge passes and returns the
// values in ascending order, flagging sets that overran the store.
//
//   channel  direction  handshake           fields
//   in_      input      in_valid/in_stall   in_value, in_last
//   out_     output     out_valid/out_stall out_sorted_value, out_last_out,
//                                           out_overflow
//
// Items are loaded into the store one at a time. A set of n stored items then
// takes ceil(log2 n) merge passes, each preceded by a setup state, and emits
// its results one by one, bounded by the single merge unit and the two-bank store.
// Reset is synchronous and clears control state; the store needs no clearing.
// in_stall rises while the two-entry intake queue is full during a sort.
// out_stall holds the output register; the core waits for it to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sorter import msort_pkg::*; #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_sorted_value,
  output logic                      out_last_out,
  output logic                      out_overflow
);

  logic    push_valid, q_full;
  qentry_t push_item;
  logic    pop_valid, pop_ready;
  qentry_t pop_item;

  // Intake and classification
  msort_front #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .in_last    (in_last),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  // Decoupling queue
  msort_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // Sort core and output register
  msort_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_item         (pop_item),
    .pop_ready        (pop_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

endmodule

`default_nettype wire

[src/msort_front.sv]
// ----------------------------------------------------------------------------
// msort_front: intake and classification
// Counts items of the current set, marks those beyond the store depth as
// dropped and reduces each value to the element width.
// ----------------------------------------------------------------------------
`default_nettype none

module msort_front import msort_pkg::*; #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_last,
  input  logic                      q_full,
  output logic                      push_valid,
  output qentry_t                   push_item
);

  localparam int ELEM_W = (DATA_WIDTH > VALUE_W) ? VALUE_W : DATA_WIDTH;
  localparam int CW     = $clog2(DEPTH + 1);

  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     accept;
  logic                     drop;
  logic signed [ELEM_W-1:0] elem;

  // Handshake: stall only when the queue has no room
  assign in_stall   = q_full;
  assign push_valid = in_valid;
  assign accept     = in_valid && !q_full;

  // Classification
  assign drop = (cnt_r == CW'(DEPTH));
  assign elem = in_value[ELEM_W-1:0];

  always_comb begin
    push_item.value = VALUE_W'(elem);
    push_item.last  = in_last;
    push_item.drop  = drop;
  end

  // Items seen in the current set, saturating at the store depth
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_last) begin
        cnt_nxt = '0;
      end else if (!drop) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[src/msort_queue.sv]
// ----------------------------------------------------------------------------
// msort_queue: short intake queue
// Two-entry FIFO that lets the front keep taking items while the core is
// busy, and lets the core load one item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msort_queue import msort_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  input  qentry_t push_item,
  output logic    full,
  output logic    pop_valid,
  output qentry_t pop_item,
  input  logic    pop_ready
);

  qentry_t             entry_r [QDEPTH];
  logic [QAW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]      cnt_r;
  logic                push, pop;

  assign full      = (cnt_r == QCW'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = entry_r[rd_ptr_r];
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[src/msort_back.sv]
// ----------------------------------------------------------------------------
// msort_back: sort core
// Loads the set into a store, runs bottom-up merge passes that ping-pong
// between two memories, then streams the sorted set into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msort_back import msort_pkg::*; #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pop_valid,
  input  qentry_t                   pop_item,
  output logic                      pop_ready,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_sorted_value,
  output logic                      out_last_out,
  output logic                      out_overflow
);

  localparam int ELEM_W = (DATA_WIDTH > VALUE_W) ? VALUE_W : DATA_WIDTH;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int WW     = CW + 2;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_MERGE = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  // Two banks: pass results alternate between them
  logic signed [ELEM_W-1:0] data_store   [DEPTH];
  logic signed [ELEM_W-1:0] merge_buffer [DEPTH];

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            n_r, n_nxt;
  logic                     dropped_r, dropped_nxt;
  logic [WW-1:0]            w_r, w_nxt;
  logic                     src_r, src_nxt;
  logic [CW-1:0]            a_r, a_nxt, b_r, b_nxt;
  logic [CW-1:0]            mid_r, mid_nxt, hi_r, hi_nxt, k_r, k_nxt;

  logic signed [ELEM_W-1:0] ds_a_r, ds_b_r, mb_a_r, mb_b_r;
  logic signed [ELEM_W-1:0] head_a, head_b, merge_val;
  logic [AW-1:0]            rd_a_addr, rd_b_addr, wr_addr;
  logic signed [ELEM_W-1:0] wr_data;
  logic                     ds_we, mb_we;

  logic                     take_a;
  logic [CW-1:0]            a_inc, k_inc;
  logic [WW-1:0]            n_w, two_w, mid_sum, hi_sum, mid_seg, hi_seg, hi_first;

  logic                     out_valid_r, out_free, load_out;
  logic signed [VALUE_W-1:0] out_value_r;
  logic                     out_last_r, out_ovf_r;

  // Heads of the two runs from the current source bank
  assign head_a = src_r ? mb_a_r : ds_a_r;
  assign head_b = src_r ? mb_b_r : ds_b_r;

  // Merge decision: left wins when strictly smaller or the right run is spent; ties go right
  assign take_a    = (a_r < mid_r) && ((b_r >= hi_r) || (head_a < head_b));
  assign merge_val = take_a ? head_a : head_b;

  assign a_inc = a_r + CW'(1);
  assign k_inc = k_r + CW'(1);

  // Segment bounds
  assign n_w      = WW'(n_r);
  assign two_w    = {w_r[WW-2:0], 1'b0};
  assign mid_sum  = WW'(hi_r) + w_r;
  assign hi_sum   = WW'(hi_r) + two_w;
  assign mid_seg  = (mid_sum < n_w) ? mid_sum : n_w;
  assign hi_seg   = (hi_sum < n_w) ? hi_sum : n_w;
  assign hi_first = (two_w < n_w) ? two_w : n_w;

  assign out_free  = !out_valid_r || !out_stall;
  assign load_out  = (state_r == ST_EMIT) && out_free;
  assign pop_ready = (state_r == ST_LOAD);

  // Read addresses follow the next pointers so data lines up with a_r, b_r
  assign rd_a_addr = a_nxt[AW-1:0];
  assign rd_b_addr = b_nxt[AW-1:0];

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    dropped_nxt = dropped_r;
    w_nxt       = w_r;
    src_nxt     = src_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    mid_nxt     = mid_r;
    hi_nxt      = hi_r;
    k_nxt       = k_r;
    ds_we       = 1'b0;
    mb_we       = 1'b0;
    wr_addr     = k_r[AW-1:0];
    wr_data     = merge_val;

    case (state_r)
      ST_LOAD: begin
        if (pop_valid) begin
          if (!pop_item.drop) begin
            ds_we   = 1'b1;
            wr_addr = n_r[AW-1:0];
            wr_data = pop_item.value[ELEM_W-1:0];
            n_nxt   = n_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (pop_item.last) begin
            w_nxt     = WW'(1);
            src_nxt   = 1'b0;
            a_nxt     = '0;
            state_nxt = ST_SETUP;
          end
        end
      end

      // Idle state before each pass: last write lands before the first reads
      ST_SETUP: begin
        if (w_r >= n_w) begin
          state_nxt = ST_EMIT;
        end else begin
          mid_nxt   = w_r[CW-1:0];
          b_nxt     = w_r[CW-1:0];
          hi_nxt    = hi_first[CW-1:0];
          k_nxt     = '0;
          state_nxt = ST_MERGE;
        end
      end

      // One element per cycle into the other bank
      ST_MERGE: begin
        ds_we = src_r;
        mb_we = !src_r;
        k_nxt = k_inc;
        if (take_a) begin
          a_nxt = a_inc;
        end else begin
          b_nxt = b_r + CW'(1);
        end
        if (k_inc == hi_r) begin
          if (hi_r == n_r) begin
            w_nxt     = two_w;
            src_nxt   = !src_r;
            a_nxt     = '0;
            state_nxt = ST_SETUP;
          end else begin
            a_nxt   = hi_r;
            mid_nxt = mid_seg[CW-1:0];
            b_nxt   = mid_seg[CW-1:0];
            hi_nxt  = hi_seg[CW-1:0];
          end
        end
      end

      // Stream sorted elements from the final bank
      ST_EMIT: begin
        if (out_free) begin
          a_nxt = a_inc;
          if (a_inc == n_r) begin
            n_nxt       = '0;
            dropped_nxt = 1'b0;
            state_nxt   = ST_LOAD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Bank 0: load target and even-pass source
  always_ff @(posedge clk) begin
    if (ds_we) begin
      data_store[wr_addr] <= wr_data;
    end
    ds_a_r <= data_store[rd_a_addr];
    ds_b_r <= data_store[rd_b_addr];
  end

  // Bank 1: odd-pass source
  always_ff @(posedge clk) begin
    if (mb_we) begin
      merge_buffer[wr_addr] <= wr_data;
    end
    mb_a_r <= merge_buffer[rd_a_addr];
    mb_b_r <= merge_buffer[rd_b_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      n_r         <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= load_out || (out_valid_r && out_stall);
    end
  end

  // Pointers and pass bookkeeping
  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    src_r <= src_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
    k_r   <= k_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value_r <= VALUE_W'(head_a);
      out_last_r  <= (a_inc == n_r);
      out_ovf_r   <= dropped_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

  // Checks
  ap_merge_write_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MERGE |-> k_r < n_r)
    else $error("merge write beyond loaded set");

  ap_merge_ptr_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MERGE |-> (a_r <= mid_r) && (b_r <= hi_r) && (hi_r <= n_r))
    else $error("merge run pointer out of bounds");

  ap_emit_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> a_r < n_r)
    else $error("emit pointer beyond loaded set");

  ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(DEPTH))
    else $error("load count exceeds store depth");

endmodule

`default_nettype wire
